// ----- src/jib_pkg.sv -----
`timescale 1ns / 1ps
package jib_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int LOCAL_COUNT = 256;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int LIDX_W      = $clog2(LOCAL_COUNT);
	localparam int Q_DEPTH     = 2;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int Q_CW        = $clog2(Q_DEPTH + 1);
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CW      = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		FLT_NONE    = 3'd0,
		FLT_UNKNOWN = 3'd1,
		FLT_UNDER   = 3'd2,
		FLT_OVER    = 3'd3,
		FLT_DIV0    = 3'd4
	} fault_t;

	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_ICONST_M = 8'h02;
	localparam logic [7:0] OP_ICONST_5 = 8'h08;
	localparam logic [7:0] OP_ICONST_0 = 8'h03;
	localparam logic [7:0] OP_BIPUSH   = 8'h10;
	localparam logic [7:0] OP_SIPUSH   = 8'h11;
	localparam logic [7:0] OP_ILOAD    = 8'h15;
	localparam logic [7:0] OP_ALOAD    = 8'h19;
	localparam logic [7:0] OP_ILOAD_0  = 8'h1a;
	localparam logic [7:0] OP_ILOAD_3  = 8'h1d;
	localparam logic [7:0] OP_ALOAD_0  = 8'h2a;
	localparam logic [7:0] OP_ALOAD_3  = 8'h2d;
	localparam logic [7:0] OP_ISTORE   = 8'h36;
	localparam logic [7:0] OP_ASTORE   = 8'h3a;
	localparam logic [7:0] OP_ISTORE_0 = 8'h3b;
	localparam logic [7:0] OP_ISTORE_3 = 8'h3e;
	localparam logic [7:0] OP_ASTORE_0 = 8'h4b;
	localparam logic [7:0] OP_ASTORE_3 = 8'h4e;
	localparam logic [7:0] OP_DUP      = 8'h59;
	localparam logic [7:0] OP_IADD     = 8'h60;
	localparam logic [7:0] OP_ISUB     = 8'h64;
	localparam logic [7:0] OP_IMUL     = 8'h68;
	localparam logic [7:0] OP_IDIV     = 8'h6c;
	localparam logic [7:0] OP_IREM     = 8'h70;
	localparam logic [7:0] OP_INEG     = 8'h74;
	localparam logic [7:0] OP_ISHL     = 8'h78;
	localparam logic [7:0] OP_ISHR     = 8'h7a;
	localparam logic [7:0] OP_IUSHR    = 8'h7c;
	localparam logic [7:0] OP_IAND     = 8'h7e;
	localparam logic [7:0] OP_IOR      = 8'h80;
	localparam logic [7:0] OP_IXOR     = 8'h82;
	localparam logic [7:0] OP_IINC     = 8'h84;
	localparam logic [7:0] OP_IFEQ     = 8'h99;
	localparam logic [7:0] OP_IFLE     = 8'h9e;
	localparam logic [7:0] OP_IFCMPEQ  = 8'h9f;
	localparam logic [7:0] OP_IFCMPLE  = 8'ha4;
	localparam logic [7:0] OP_GOTO     = 8'ha7;
	localparam logic [7:0] OP_IRETURN  = 8'hac;
	localparam logic [7:0] OP_ARETURN  = 8'hb0;
	localparam logic [7:0] OP_RETURN   = 8'hb1;
	localparam logic [7:0] OP_INVVIRT  = 8'hb6;

	typedef enum logic [4:0] {
		K_NOP, K_CONST, K_LOAD, K_STORE, K_DUP, K_ADD, K_SUB, K_MUL, K_DIV, K_REM,
		K_NEG, K_SHL, K_SHR, K_USHR, K_AND, K_OR, K_XOR, K_IINC, K_IF1, K_IF2,
		K_GOTO, K_PRINT, K_RET, K_RETV, K_BAD
	} kind_t;

	typedef enum logic [2:0] {C_EQ, C_NE, C_LT, C_GE, C_GT, C_LE} cond_t;

	typedef enum logic [2:0] {B_IDLE, B_EXEC, B_MUL, B_DIV, B_WB} bstate_t;

	typedef struct packed {
		kind_t              kind;
		logic [1:0]         npop;
		logic [1:0]         npush;
		logic [1:0]         len;
		logic [LIDX_W-1:0]  lidx;
		cond_t              cond;
		logic [15:0]        off;
		logic [31:0]        cval;
	} entry_t;

endpackage

// ----- src/jvm_integer_bytecode_core.sv -----
`timescale 1ns / 1ps
// Integer JVM bytecode core: one bytecode per input transaction, one result per input.
// Input channel: in_valid/in_stall with opcode and two operand bytes. A transaction
// completes on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with pc_step, print, return, finished and fault.
// The front decodes each opcode into a two-entry queue; the back reads the operand
// stack and locals (registered memory reads), executes, and writes back.
// Steps from acceptance to out_valid: queue write, then read, execute and write back;
// imul adds a multiply step, and idiv and irem wait in a divide state for the
// bit-serial divider. The back end takes a new item only after the previous one
// has been written back: each item needs the stack count the previous
// one leaves, so the back sequencer handles one item at a time.
// The output register holds a result while out_stall is high; the back end then waits
// in write-back and the queue fills, after which in_stall rises.
// Reset (arst_n low): stack empty, all locals read as zero, not halted, queue empty,
// no result pending. After a return every item yields finished only.
module jvm_integer_bytecode_core import jib_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  opcode,
	input  logic [7:0]  first_operand,
	input  logic [7:0]  second_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pc_step,
	output logic        print_valid,
	output logic [31:0] print_value,
	output logic        finished,
	output logic        return_valid,
	output logic [31:0] return_value,
	output logic [2:0]  fault
);

	logic   q_push, q_full, q_pop, q_valid;
	entry_t push_ent, head_ent;

	jib_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_ent          (push_ent)
	);

	jib_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ent   (push_ent),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (head_ent)
	);

	jib_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ent        (head_ent),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pc_step      (pc_step),
		.print_valid  (print_valid),
		.print_value  (print_value),
		.finished     (finished),
		.return_valid (return_valid),
		.return_value (return_value),
		.fault        (fault)
	);

	a_fault_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault != FLT_NONE |-> pc_step == 16'd0)
		else $error("faulting result with nonzero pc step");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault != FLT_NONE |-> !print_valid && !return_valid && !finished)
		else $error("faulting result carries side effects");

	a_ret_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && return_valid |-> finished && !print_valid)
		else $error("return value without finished");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

// ----- src/jib_front.sv -----
`timescale 1ns / 1ps
module jib_front import jib_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] opcode,
	input  logic [7:0] first_operand,
	input  logic [7:0] second_operand,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_ent
);

	logic [7:0] d8;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_ent       = '0;
		q_ent.kind  = K_BAD;
		q_ent.cond  = C_EQ;
		q_ent.len   = 2'd1;
		q_ent.off   = {first_operand, second_operand};
		q_ent.lidx  = first_operand[LIDX_W-1:0];
		d8          = 8'd0;
		unique case (opcode) inside
			OP_NOP: q_ent.kind = K_NOP;
			[OP_ICONST_M:OP_ICONST_5]: begin
				d8 = opcode - OP_ICONST_0;
				q_ent.kind = K_CONST; q_ent.npush = 2'd1;
				q_ent.cval = {{24{d8[7]}}, d8};
			end
			OP_BIPUSH: begin
				q_ent.kind = K_CONST; q_ent.npush = 2'd1; q_ent.len = 2'd2;
				q_ent.cval = {{24{first_operand[7]}}, first_operand};
			end
			OP_SIPUSH: begin
				q_ent.kind = K_CONST; q_ent.npush = 2'd1; q_ent.len = 2'd3;
				q_ent.cval = {{16{first_operand[7]}}, first_operand, second_operand};
			end
			OP_ILOAD, OP_ALOAD: begin
				q_ent.kind = K_LOAD; q_ent.npush = 2'd1; q_ent.len = 2'd2;
			end
			[OP_ILOAD_0:OP_ILOAD_3]: begin
				d8 = opcode - OP_ILOAD_0;
				q_ent.kind = K_LOAD; q_ent.npush = 2'd1; q_ent.lidx = d8[LIDX_W-1:0];
			end
			[OP_ALOAD_0:OP_ALOAD_3]: begin
				d8 = opcode - OP_ALOAD_0;
				q_ent.kind = K_LOAD; q_ent.npush = 2'd1; q_ent.lidx = d8[LIDX_W-1:0];
			end
			OP_ISTORE, OP_ASTORE: begin
				q_ent.kind = K_STORE; q_ent.npop = 2'd1; q_ent.len = 2'd2;
			end
			[OP_ISTORE_0:OP_ISTORE_3]: begin
				d8 = opcode - OP_ISTORE_0;
				q_ent.kind = K_STORE; q_ent.npop = 2'd1; q_ent.lidx = d8[LIDX_W-1:0];
			end
			[OP_ASTORE_0:OP_ASTORE_3]: begin
				d8 = opcode - OP_ASTORE_0;
				q_ent.kind = K_STORE; q_ent.npop = 2'd1; q_ent.lidx = d8[LIDX_W-1:0];
			end
			OP_DUP: begin q_ent.kind = K_DUP; q_ent.npop = 2'd1; q_ent.npush = 2'd2; end
			OP_INEG: begin q_ent.kind = K_NEG; q_ent.npop = 2'd1; q_ent.npush = 2'd1; end
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR, OP_IUSHR,
			OP_IAND, OP_IOR, OP_IXOR: begin
				q_ent.npop = 2'd2; q_ent.npush = 2'd1;
				case (opcode)
					OP_IADD:  q_ent.kind = K_ADD;
					OP_ISUB:  q_ent.kind = K_SUB;
					OP_IMUL:  q_ent.kind = K_MUL;
					OP_IDIV:  q_ent.kind = K_DIV;
					OP_IREM:  q_ent.kind = K_REM;
					OP_ISHL:  q_ent.kind = K_SHL;
					OP_ISHR:  q_ent.kind = K_SHR;
					OP_IUSHR: q_ent.kind = K_USHR;
					OP_IAND:  q_ent.kind = K_AND;
					OP_IOR:   q_ent.kind = K_OR;
					default:  q_ent.kind = K_XOR;
				endcase
			end
			OP_IINC: begin q_ent.kind = K_IINC; q_ent.len = 2'd3; end
			[OP_IFEQ:OP_IFLE]: begin
				d8 = opcode - OP_IFEQ;
				q_ent.kind = K_IF1; q_ent.npop = 2'd1; q_ent.len = 2'd3;
				q_ent.cond = cond_t'(d8[2:0]);
			end
			[OP_IFCMPEQ:OP_IFCMPLE]: begin
				d8 = opcode - OP_IFCMPEQ;
				q_ent.kind = K_IF2; q_ent.npop = 2'd2; q_ent.len = 2'd3;
				q_ent.cond = cond_t'(d8[2:0]);
			end
			OP_GOTO: q_ent.kind = K_GOTO;
			OP_INVVIRT: begin q_ent.kind = K_PRINT; q_ent.npop = 2'd1; q_ent.len = 2'd3; end
			OP_IRETURN, OP_ARETURN: begin q_ent.kind = K_RETV; q_ent.npop = 2'd1; end
			OP_RETURN: q_ent.kind = K_RET;
			default: q_ent.kind = K_BAD;
		endcase
	end

endmodule

// ----- src/jib_queue.sv -----
`timescale 1ns / 1ps
module jib_queue import jib_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_ent,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_CW-1:0] cnt_q;

	assign full       = (cnt_q == Q_CW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- src/jib_div.sv -----
`timescale 1ns / 1ps
module jib_div import jib_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        want_rem,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] result
);

	logic              busy_q, done_q, rem_sel_q, qneg_q, rneg_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [31:0]       num_q, den_q;
	logic [32:0]       rem_q, shifted, trial;
	logic [31:0]       quo, rmd;

	// restoring division on magnitudes, one quotient bit per cycle
	assign shifted = {rem_q[31:0], num_q[31]};
	assign trial   = shifted - {1'b0, den_q};
	assign quo     = qneg_q ? 32'd0 - num_q : num_q;
	assign rmd     = rneg_q ? 32'd0 - rem_q[31:0] : rem_q[31:0];
	assign result  = rem_sel_q ? rmd : quo;
	assign done    = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q     <= dividend[31] ? 32'd0 - dividend : dividend;
			den_q     <= divisor[31] ? 32'd0 - divisor : divisor;
			rem_q     <= '0;
			qneg_q    <= dividend[31] ^ divisor[31];
			rneg_q    <= dividend[31];
			rem_sel_q <= want_rem;
		end else if (busy_q) begin
			rem_q <= trial[32] ? shifted : trial;
			num_q <= {num_q[30:0], ~trial[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/jib_back.sv -----
`timescale 1ns / 1ps
module jib_back import jib_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  entry_t       q_ent,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [15:0]  pc_step,
	output logic         print_valid,
	output logic [31:0]  print_value,
	output logic         finished,
	output logic         return_valid,
	output logic [31:0]  return_value,
	output logic [2:0]   fault
);

	bstate_t state_q, state_d;
	entry_t  ent_q;

	logic [CNT_W-1:0]  cnt_q, new_cnt;
	logic              halted_q;

	logic [31:0]       stk_mem [STACK_DEPTH];
	logic [31:0]       stk_a_q, stk_b_q;
	logic [STK_AW-1:0] addr_a, addr_b, stk_wa;

	logic [31:0]       loc_mem [LOCAL_COUNT];
	logic [LOCAL_COUNT-1:0] loc_vld_q;
	logic [31:0]       loc_raw_q, loc_val;
	logic              loc_hit_q;

	logic              rd_en, go_mul, go_div, div_start, div_done, wb_go, out_free;
	logic [31:0]       div_res;

	fault_t            ex_flt, flt_q;
	logic [31:0]       ex_res, res_q, cx, cy;
	logic [15:0]       ex_step, step_q;
	logic              hlt_item_q, take, ok;
	logic [CNT_W:0]    after;

	logic              ov_q, pv_q, fin_q, rv_q;
	logic [15:0]       step_o_q;
	logic [31:0]       pval_q, rval_q;
	fault_t            flt_o_q;

	assign addr_b   = STK_AW'(cnt_q - CNT_W'(1));
	assign addr_a   = STK_AW'(cnt_q - CNT_W'(2));
	assign loc_val  = loc_hit_q ? loc_raw_q : 32'd0;
	assign out_free = !ov_q || !out_stall;
	assign after    = {1'b0, cnt_q} - (CNT_W + 1)'(ent_q.npop) + (CNT_W + 1)'(ent_q.npush);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) state_d = B_EXEC;
			B_EXEC: state_d = go_mul ? B_MUL : (go_div ? B_DIV : B_WB);
			B_MUL:  state_d = B_WB;
			B_DIV:  if (div_done) state_d = B_WB;
			B_WB:   if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en     = 1'b0;
		div_start = 1'b0;
		wb_go     = 1'b0;
		unique case (state_q)
			B_IDLE: rd_en = q_valid;
			B_EXEC: div_start = go_div;
			B_WB:   wb_go = out_free;
			default: ;
		endcase
	end
	assign q_pop = rd_en;

	// execute: fault checks, result and pc step
	always_comb begin
		cx = (ent_q.kind == K_IF1) ? stk_b_q : stk_a_q;
		cy = (ent_q.kind == K_IF1) ? 32'd0 : stk_b_q;
		case (ent_q.cond)
			C_EQ:    take = (cx == cy);
			C_NE:    take = (cx != cy);
			C_LT:    take = ($signed(cx) <  $signed(cy));
			C_GE:    take = ($signed(cx) >= $signed(cy));
			C_GT:    take = ($signed(cx) >  $signed(cy));
			default: take = ($signed(cx) <= $signed(cy));
		endcase

		if (ent_q.kind == K_BAD)                         ex_flt = FLT_UNKNOWN;
		else if (cnt_q < CNT_W'(ent_q.npop))              ex_flt = FLT_UNDER;
		else if (after > (CNT_W + 1)'(STACK_DEPTH))       ex_flt = FLT_OVER;
		else if ((ent_q.kind == K_DIV || ent_q.kind == K_REM) && stk_b_q == 32'd0)
			ex_flt = FLT_DIV0;
		else                                              ex_flt = FLT_NONE;

		ex_step = {14'd0, ent_q.len};
		ex_res  = stk_b_q;
		case (ent_q.kind)
			K_CONST: ex_res = ent_q.cval;
			K_LOAD:  ex_res = loc_val;
			K_ADD:   ex_res = stk_a_q + stk_b_q;
			K_SUB:   ex_res = stk_a_q - stk_b_q;
			K_NEG:   ex_res = 32'd0 - stk_b_q;
			K_SHL:   ex_res = stk_a_q << stk_b_q[4:0];
			K_SHR:   ex_res = $unsigned($signed(stk_a_q) >>> stk_b_q[4:0]);
			K_USHR:  ex_res = stk_a_q >> stk_b_q[4:0];
			K_AND:   ex_res = stk_a_q & stk_b_q;
			K_OR:    ex_res = stk_a_q | stk_b_q;
			K_XOR:   ex_res = stk_a_q ^ stk_b_q;
			K_IINC:  ex_res = loc_val + {{24{ent_q.off[7]}}, ent_q.off[7:0]};
			K_IF1, K_IF2: if (take) ex_step = ent_q.off;
			K_GOTO:  ex_step = ent_q.off;
			K_RET, K_RETV: ex_step = 16'd0;
			default: ;
		endcase
		if (ex_flt != FLT_NONE) ex_step = 16'd0;

		ok     = !halted_q && ex_flt == FLT_NONE;
		go_mul = ok && ent_q.kind == K_MUL;
		go_div = ok && (ent_q.kind == K_DIV || ent_q.kind == K_REM);
	end

	jib_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.want_rem (ent_q.kind == K_REM),
		.dividend (stk_a_q),
		.divisor  (stk_b_q),
		.done     (div_done),
		.result   (div_res)
	);

	// stack and locals storage
	always_ff @(posedge clk) begin
		if (rd_en) begin
			stk_b_q   <= stk_mem[addr_b];
			stk_a_q   <= stk_mem[addr_a];
			loc_raw_q <= loc_mem[q_ent.lidx];
			loc_hit_q <= loc_vld_q[q_ent.lidx];
			ent_q     <= q_ent;
		end
		if (wb_go && !hlt_item_q && flt_q == FLT_NONE && ent_q.npush != 2'd0)
			stk_mem[stk_wa] <= res_q;
		if (wb_go && !hlt_item_q && flt_q == FLT_NONE &&
		    (ent_q.kind == K_STORE || ent_q.kind == K_IINC))
			loc_mem[ent_q.lidx] <= res_q;
		if (state_q == B_EXEC) begin
			flt_q      <= halted_q ? FLT_NONE : ex_flt;
			step_q     <= halted_q ? 16'd0 : ex_step;
			res_q      <= ex_res;
			hlt_item_q <= halted_q;
		end else if (state_q == B_MUL) begin
			res_q <= stk_a_q * stk_b_q;
		end else if (state_q == B_DIV && div_done) begin
			res_q <= div_res;
		end
	end

	assign new_cnt = CNT_W'(after);
	assign stk_wa  = STK_AW'(new_cnt - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			halted_q  <= 1'b0;
			loc_vld_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb_go) begin
				ov_q <= 1'b1;
				if (!hlt_item_q && flt_q == FLT_NONE) begin
					if (ent_q.kind == K_RET || ent_q.kind == K_RETV) begin
						cnt_q    <= '0;
						halted_q <= 1'b1;
					end else begin
						cnt_q <= new_cnt;
					end
					if (ent_q.kind == K_STORE || ent_q.kind == K_IINC)
						loc_vld_q[ent_q.lidx] <= 1'b1;
				end
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (wb_go) begin
			step_o_q <= step_q;
			flt_o_q  <= flt_q;
			pv_q     <= !hlt_item_q && flt_q == FLT_NONE && ent_q.kind == K_PRINT;
			pval_q   <= (!hlt_item_q && flt_q == FLT_NONE && ent_q.kind == K_PRINT)
			            ? res_q : 32'd0;
			rv_q     <= !hlt_item_q && flt_q == FLT_NONE && ent_q.kind == K_RETV;
			rval_q   <= (!hlt_item_q && flt_q == FLT_NONE && ent_q.kind == K_RETV)
			            ? res_q : 32'd0;
			fin_q    <= hlt_item_q || (flt_q == FLT_NONE &&
			            (ent_q.kind == K_RET || ent_q.kind == K_RETV));
		end
	end

	assign out_valid    = ov_q;
	assign pc_step      = step_o_q;
	assign print_valid  = pv_q;
	assign print_value  = pval_q;
	assign finished     = fin_q;
	assign return_valid = rv_q;
	assign return_value = rval_q;
	assign fault        = flt_o_q;

endmodule
